// ----- rtl/core/tmr_pkg.sv -----
package tmr_pkg;

    // Default width of the cycle count carried by one tick
    localparam int DEFAULT_CYCLE_BITS = 10;

    // Field and state widths
    localparam int DIV_W      = 16;
    localparam int DIV_FRAC_W = 8;
    localparam int BYTE_W     = 8;
    localparam int CTRL_W     = 3;
    // Counter fraction after a tick stays below the longest period (1024)
    localparam int CNT_FRAC_W = 10;

    // Request codes
    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_READ  = 2'd1,
        REQ_WRITE = 2'd2,
        REQ_POLL  = 2'd3
    } req_t;

    // Register offsets
    localparam logic [15:0] OFF_DIV_LO = 16'd0;
    localparam logic [15:0] OFF_DIV_HI = 16'd1;
    localparam logic [15:0] OFF_CNT    = 16'd2;
    localparam logic [15:0] OFF_MOD    = 16'd3;
    localparam logic [15:0] OFF_CTRL   = 16'd4;

    // Counter rate select in control bits 1:0
    typedef enum logic [1:0] {
        RATE_1024 = 2'd0,
        RATE_16   = 2'd1,
        RATE_64   = 2'd2,
        RATE_256  = 2'd3
    } rate_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STEP,
        ST_EMIT
    } state_t;

    // Status from the step unit back to the sequencer
    typedef struct packed {
        logic              done;
        logic              wrap;
        logic [BYTE_W-1:0] counter;
    } step_status_t;

    // log2 of the counter period for a rate select
    function automatic logic [3:0] period_shift(input rate_t rate);
        logic [3:0] sh;
        unique case (rate)
            RATE_16:   sh = 4'd4;
            RATE_64:   sh = 4'd6;
            RATE_256:  sh = 4'd8;
            RATE_1024: sh = 4'd10;
        endcase
        return sh;
    endfunction

endpackage

// ----- rtl/core/tmr_step_unit.sv -----
module tmr_step_unit #(
    parameter int STEP_W = 7
) (
    input  logic                          aclk,
    input  logic                          start,
    input  logic                          advance,
    input  logic [STEP_W-1:0]             steps,
    input  logic [tmr_pkg::BYTE_W-1:0]    counter,
    input  logic [tmr_pkg::BYTE_W-1:0]    modulo,
    output tmr_pkg::step_status_t         status
);
    import tmr_pkg::*;

    localparam int CMP_W = (STEP_W > BYTE_W + 1) ? STEP_W : BYTE_W + 1;

    logic [STEP_W-1:0] remaining_reg;
    logic [STEP_W-1:0] remaining_next;
    logic [BYTE_W:0]   room;
    logic [CMP_W-1:0]  rem_ext;
    logic [CMP_W-1:0]  room_ext;

    // One pass: either finish inside the current wrap, or run to the wrap and reload
    always_comb begin
        room     = (BYTE_W+1)'(1 << BYTE_W) - {1'b0, counter};
        rem_ext  = CMP_W'(remaining_reg);
        room_ext = CMP_W'(room);
        if (rem_ext < room_ext) begin
            status.done    = 1'b1;
            status.wrap    = 1'b0;
            status.counter = counter + BYTE_W'(rem_ext);
            remaining_next = '0;
        end else begin
            status.done    = (rem_ext == room_ext);
            status.wrap    = 1'b1;
            status.counter = modulo;
            remaining_next = STEP_W'(rem_ext - room_ext);
        end
    end

    // Steps still to apply
    always_ff @(posedge aclk) begin
        if (start) begin
            remaining_reg <= steps;
        end else if (advance) begin
            remaining_reg <= remaining_next;
        end
    end

endmodule

// ----- rtl/core/divider_and_reload_timer.sv -----
// Timer with a free 16-bit divider fed by the carry of an 8-bit fraction, and an
// 8-bit counter stepping at the rate in control bits 1:0 while bit 2 is set,
// reloading from the modulo register and raising the interrupt flag when it
// passes 0xFF. Each request gives exactly one result. Read, write and poll
// requests go from ST_IDLE to ST_EMIT and then to the output register. A tick
// that steps the counter also passes through ST_STEP, making one pass through the
// shared step unit per counter wrap inside the tick, plus one more when steps are
// left over after the last wrap; a tick with no counter step goes like a read.
// The step unit does one compare and subtract per cycle, so a tick with many
// wraps (small modulo distance, fast rate, large cycle count) takes
// correspondingly longer.
// s_ready is high only while the sequencer is idle; a finished result sits in
// the output register while the next request is taken.
module divider_and_reload_timer #(
    parameter int CYCLE_BITS = tmr_pkg::DEFAULT_CYCLE_BITS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_req_type,
    input  logic [CYCLE_BITS-1:0]        s_cycle_count,
    input  logic [15:0]                  s_reg_offset,
    input  logic [tmr_pkg::BYTE_W-1:0]   s_write_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [tmr_pkg::BYTE_W-1:0]   m_read_data,
    output logic                         m_irq_flag
);
    import tmr_pkg::*;

    localparam int ACC_W  = ((CYCLE_BITS > DIV_FRAC_W) ? CYCLE_BITS : DIV_FRAC_W) + 1;
    localparam int SUM_W  = ((CYCLE_BITS > CNT_FRAC_W) ? CYCLE_BITS : CNT_FRAC_W) + 1;
    localparam int STEP_W = SUM_W - 4;

    // Architectural state
    logic [DIV_W-1:0]      divider_reg;
    logic [DIV_FRAC_W-1:0] div_frac_reg;
    logic [BYTE_W-1:0]     counter_reg;
    logic [BYTE_W-1:0]     modulo_reg;
    logic [CTRL_W-1:0]     control_reg;
    logic [CNT_FRAC_W-1:0] cnt_frac_reg;
    logic                  irq_pending_reg;

    // Sequencer and result holding
    state_t                state_reg;
    state_t                state_next;
    logic [BYTE_W-1:0]     res_rd_reg;
    logic                  res_irq_reg;
    logic                  is_poll_reg;
    logic                  m_valid_reg;
    logic [BYTE_W-1:0]     m_read_data_reg;
    logic                  m_irq_flag_reg;

    // Control
    logic                  accept;
    logic                  step_advance;
    logic                  emit_ok;
    req_t                  req;

    // Tick datapath
    logic [ACC_W-1:0]      acc;
    logic [SUM_W-1:0]      cnt_sum;
    logic [3:0]            shift;
    logic [SUM_W-1:0]      frac_mask;
    logic [STEP_W-1:0]     tick_steps;
    logic [CNT_FRAC_W-1:0] cnt_frac_new;
    logic                  need_steps;
    logic [BYTE_W-1:0]     rd_value;

    step_status_t          step_status;

    assign req    = req_t'(s_req_type);
    assign accept = s_valid && s_ready;

    // Divider and counter arithmetic for a tick
    always_comb begin
        acc          = ACC_W'(div_frac_reg) + ACC_W'(s_cycle_count);
        cnt_sum      = SUM_W'(cnt_frac_reg) + SUM_W'(s_cycle_count);
        shift        = period_shift(rate_t'(control_reg[1:0]));
        frac_mask    = (SUM_W'(1) << shift) - SUM_W'(1);
        tick_steps   = STEP_W'(cnt_sum >> shift);
        cnt_frac_new = CNT_FRAC_W'(cnt_sum & frac_mask);
        need_steps   = (req == REQ_TICK) && control_reg[2] && (tick_steps != '0);
    end

    // Register read mux
    always_comb begin
        unique case (s_reg_offset)
            OFF_DIV_LO: rd_value = divider_reg[BYTE_W-1:0];
            OFF_DIV_HI: rd_value = divider_reg[DIV_W-1:BYTE_W];
            OFF_CNT:    rd_value = counter_reg;
            OFF_MOD:    rd_value = modulo_reg;
            OFF_CTRL:   rd_value = BYTE_W'(control_reg);
            default:    rd_value = '0;
        endcase
    end

    // Sequencer next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = need_steps ? ST_STEP : ST_EMIT;
                end
            end
            ST_STEP: begin
                if (step_status.done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (emit_ok) begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_ready      = 1'b0;
        step_advance = 1'b0;
        emit_ok      = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_ready      = 1'b1;
            ST_STEP: step_advance = 1'b1;
            ST_EMIT: emit_ok      = !m_valid_reg || m_ready;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Shared counter step unit
    tmr_step_unit #(
        .STEP_W (STEP_W)
    ) u_step (
        .aclk    (aclk),
        .start   (accept && need_steps),
        .advance (step_advance),
        .steps   (tick_steps),
        .counter (counter_reg),
        .modulo  (modulo_reg),
        .status  (step_status)
    );

    // Timer state updates
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            divider_reg     <= '0;
            div_frac_reg    <= '0;
            counter_reg     <= '0;
            modulo_reg      <= '0;
            control_reg     <= '0;
            cnt_frac_reg    <= '0;
            irq_pending_reg <= 1'b0;
        end else if (accept) begin
            unique case (req)
                REQ_TICK: begin
                    divider_reg  <= divider_reg + DIV_W'(acc[ACC_W-1:DIV_FRAC_W]);
                    div_frac_reg <= acc[DIV_FRAC_W-1:0];
                    if (control_reg[2]) begin
                        cnt_frac_reg <= cnt_frac_new;
                    end
                end
                REQ_WRITE: begin
                    unique case (s_reg_offset)
                        OFF_DIV_LO, OFF_DIV_HI: begin
                            divider_reg  <= '0;
                            div_frac_reg <= '0;
                        end
                        OFF_CNT:  counter_reg <= s_write_data;
                        OFF_MOD:  modulo_reg  <= s_write_data;
                        OFF_CTRL: control_reg <= s_write_data[CTRL_W-1:0];
                        default: ;
                    endcase
                end
                REQ_POLL:  irq_pending_reg <= 1'b0;
                REQ_READ: ;
            endcase
        end else if (step_advance) begin
            counter_reg <= step_status.counter;
            if (step_status.wrap) begin
                irq_pending_reg <= 1'b1;
            end
        end
    end

    // Result captured at transfer
    always_ff @(posedge aclk) begin
        if (accept) begin
            res_rd_reg  <= (req == REQ_READ) ? rd_value : '0;
            res_irq_reg <= irq_pending_reg;
            is_poll_reg <= (req == REQ_POLL);
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit_ok) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_ok) begin
            m_read_data_reg <= res_rd_reg;
            m_irq_flag_reg  <= is_poll_reg ? res_irq_reg : irq_pending_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_read_data = m_read_data_reg;
    assign m_irq_flag  = m_irq_flag_reg;

`ifndef SYNTHESIS
    // A poll always leaves the flag clear
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && req == REQ_POLL) |=> !irq_pending_reg)
        else $error("irq flag not cleared by poll");

    // A counter wrap during stepping sets the flag
    assert property (@(posedge aclk) disable iff (!aresetn)
        (step_advance && step_status.wrap) |=> irq_pending_reg)
        else $error("counter wrap did not raise irq flag");

    // Results only come out of the emit state
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("result presented outside emit state");

    // Stepping only starts on a tick with the counter enabled
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && state_next == ST_STEP) |-> (req == REQ_TICK && control_reg[2]))
        else $error("step sequence started without an enabled tick");
`endif

endmodule

// ----- bench/divider_and_reload_timer_tb.sv -----
module divider_and_reload_timer_tb;

    import tmr_pkg::*;

    localparam int CYC_W        = DEFAULT_CYCLE_BITS;
    localparam int N_REQUESTS   = 1900;
    localparam int QUIET_TAIL   = 150;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 100;

    // Expected result of one request
    typedef struct packed {
        logic [BYTE_W-1:0] rd;
        logic              irq;
    } timer_resp_t;

    // One row of the directed sequence; known marks a hand-typed result
    typedef struct {
        req_t              req;
        logic [CYC_W-1:0]  cyc;
        logic [15:0]       off;
        logic [BYTE_W-1:0] data;
        bit                known;
        logic [BYTE_W-1:0] rd;
        logic              irq;
    } timer_step_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [1:0]           s_req_type = 2'd0;
    logic [CYC_W-1:0]     s_cycle_count = '0;
    logic [15:0]          s_reg_offset = '0;
    logic [BYTE_W-1:0]    s_write_data = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [BYTE_W-1:0]    m_read_data;
    logic                 m_irq_flag;

    timer_resp_t pending_responses[$];
    timer_step_t plan[$];
    int          error_count = 0;
    int          responses_seen = 0;
    bit          no_idle = 1'b0;
    bit          quiet_tail = 1'b0;

    // Shadow copy of the timer state
    logic [DIV_W-1:0]      div_count;
    logic [DIV_FRAC_W-1:0] div_phase;
    logic [BYTE_W-1:0]     cnt_value;
    logic [BYTE_W-1:0]     cnt_reload;
    logic [CTRL_W-1:0]     ctrl_bits;
    int unsigned           cnt_phase;
    logic                  irq_state;

    divider_and_reload_timer #(
        .CYCLE_BITS(CYC_W)
    ) u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_cycle_count(s_cycle_count),
        .s_reg_offset (s_reg_offset),
        .s_write_data (s_write_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_data  (m_read_data),
        .m_irq_flag   (m_irq_flag)
    );

    always #1 aclk = ~aclk;

    // Counter period for the current rate select
    function automatic int unsigned tima_period(input logic [CTRL_W-1:0] ctrl);
        int unsigned p;
        case (rate_t'(ctrl[1:0]))
            RATE_16:  p = 16;
            RATE_64:  p = 64;
            RATE_256: p = 256;
            default:  p = 1024;
        endcase
        return p;
    endfunction

    // Apply one request to the shadow state and return its result
    function automatic timer_resp_t apply_timer_request(input req_t req,
                                                        input logic [CYC_W-1:0] cyc,
                                                        input logic [15:0] off,
                                                        input logic [BYTE_W-1:0] data);
        timer_resp_t r;
        int unsigned acc;
        int unsigned period;
        r.rd  = '0;
        r.irq = 1'b0;
        case (req)
            REQ_TICK: begin
                acc       = div_phase + cyc;
                div_count = div_count + DIV_W'(acc >> 8);
                div_phase = acc[DIV_FRAC_W-1:0];
                if (ctrl_bits[2]) begin
                    cnt_phase += cyc;
                    period = tima_period(ctrl_bits);
                    while (cnt_phase >= period) begin
                        cnt_phase -= period;
                        if (cnt_value == 8'hFF) begin
                            cnt_value = cnt_reload;
                            irq_state = 1'b1;
                        end else begin
                            cnt_value = cnt_value + 8'd1;
                        end
                    end
                end
                r.irq = irq_state;
            end
            REQ_READ: begin
                case (off)
                    OFF_DIV_LO: r.rd = div_count[7:0];
                    OFF_DIV_HI: r.rd = div_count[15:8];
                    OFF_CNT:    r.rd = cnt_value;
                    OFF_MOD:    r.rd = cnt_reload;
                    OFF_CTRL:   r.rd = BYTE_W'(ctrl_bits);
                    default:    r.rd = '0;
                endcase
                r.irq = irq_state;
            end
            REQ_WRITE: begin
                case (off)
                    OFF_DIV_LO, OFF_DIV_HI: begin
                        div_count = '0;
                        div_phase = '0;
                    end
                    OFF_CNT:  cnt_value  = data;
                    OFF_MOD:  cnt_reload = data;
                    OFF_CTRL: ctrl_bits  = data[CTRL_W-1:0];
                    default: ;
                endcase
                r.irq = irq_state;
            end
            default: begin
                r.irq     = irq_state;
                irq_state = 1'b0;
            end
        endcase
        return r;
    endfunction

    // Offer one request; record its expected result once transferred
    task automatic issue_request(input timer_step_t st);
        int          gap;
        timer_resp_t predicted;
        if (!no_idle && !quiet_tail && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge aclk);
                s_valid <= 1'b0;
            end
        end
        @(negedge aclk);
        s_valid       <= 1'b1;
        s_req_type    <= st.req;
        s_cycle_count <= st.cyc;
        s_reg_offset  <= st.off;
        s_write_data  <= st.data;
        do @(posedge aclk); while (!s_ready);
        predicted = apply_timer_request(st.req, st.cyc, st.off, st.data);
        if (st.known)
            pending_responses.push_back('{rd: st.rd, irq: st.irq});
        else
            pending_responses.push_back(predicted);
    endtask

    // Random request, biased toward real register offsets and short ticks
    function automatic timer_step_t random_request();
        timer_step_t st;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)      st.req = REQ_TICK;
        else if (pick < 65) st.req = REQ_READ;
        else if (pick < 85) st.req = REQ_WRITE;
        else                st.req = REQ_POLL;
        pick = $urandom_range(0, 99);
        if (pick < 75)      st.cyc = CYC_W'($urandom_range(0, 63));
        else if (pick < 95) st.cyc = CYC_W'($urandom_range(0, 1023));
        else                st.cyc = (pick[0]) ? '1 : '0;
        pick = $urandom_range(0, 99);
        if (pick < 80)      st.off = 16'($urandom_range(0, 4));
        else if (pick < 90) st.off = 16'($urandom_range(5, 15));
        else                st.off = 16'($urandom_range(0, 65535));
        st.data = 8'($urandom_range(0, 255));
        // High reload values make wraps frequent
        if (st.req == REQ_WRITE && st.off == OFF_MOD && $urandom_range(0, 1))
            st.data = 8'($urandom_range(8'hF0, 8'hFF));
        st.known = 1'b0;
        st.rd    = '0;
        st.irq   = 1'b0;
        return st;
    endfunction

    // Result side: random back-pressure plus one long hold
    initial begin
        int  stall_left;
        bit  hold_done;
        stall_left = 0;
        hold_done  = 1'b0;
        forever begin
            @(negedge aclk);
            if (quiet_tail) begin
                m_ready <= 1'b1;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (!hold_done && responses_seen >= HOLD_AT) begin
                hold_done  = 1'b1;
                stall_left = HOLD_CYCLES - 1;
                m_ready <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 6) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Compare each transferred result with the oldest expectation
    always @(posedge aclk) begin
        timer_resp_t want;
        if (aresetn && m_valid && m_ready) begin
            responses_seen++;
            if (pending_responses.size() == 0) begin
                $error("unexpected result: read_data=%0h irq_flag=%0b",
                       m_read_data, m_irq_flag);
                error_count++;
            end else begin
                want = pending_responses.pop_front();
                if (m_read_data !== want.rd) begin
                    $error("read_data: expected %0h, got %0h", want.rd, m_read_data);
                    error_count++;
                end
                if (m_irq_flag !== want.irq) begin
                    $error("irq_flag: expected %0b, got %0b", want.irq, m_irq_flag);
                    error_count++;
                end
            end
        end
    end

    // Main sequence
    initial begin
        int n_random;
        div_count  = '0;
        div_phase  = '0;
        cnt_value  = '0;
        cnt_reload = '0;
        ctrl_bits  = '0;
        cnt_phase  = 0;
        irq_state  = 1'b0;

        // Directed: reset values, extremes and the corner behaviors
        plan.push_back('{REQ_READ,  10'd0,    OFF_DIV_LO, 8'h00, 1, 8'h00, 1'b0});
        plan.push_back('{REQ_READ,  10'd0,    OFF_DIV_HI, 8'h00, 1, 8'h00, 1'b0});
        plan.push_back('{REQ_READ,  10'd0,    OFF_CNT,    8'h00, 1, 8'h00, 1'b0});
        plan.push_back('{REQ_READ,  10'd0,    OFF_MOD,    8'h00, 1, 8'h00, 1'b0});
        plan.push_back('{REQ_READ,  10'd0,    OFF_CTRL,   8'h00, 1, 8'h00, 1'b0});
        // unknown offset reads zero
        plan.push_back('{REQ_READ,  10'd0,    16'hFFFF,   8'hFF, 1, 8'h00, 1'b0});
        // counter disabled: only the divider moves
        plan.push_back('{REQ_TICK,  10'h3FF,  16'h0000,   8'h00, 1, 8'h00, 1'b0});
        plan.push_back('{REQ_READ,  10'd0,    OFF_DIV_LO, 8'h00, 0, 8'h00, 1'b0});
        plan.push_back('{REQ_READ,  10'd0,    OFF_CNT,    8'h00, 1, 8'h00, 1'b0});
        // divider write clears regardless of data
        plan.push_back('{REQ_WRITE, 10'd0,    OFF_DIV_HI, 8'hAA, 1, 8'h00, 1'b0});
        plan.push_back('{REQ_READ,  10'd0,    OFF_DIV_LO, 8'h00, 1, 8'h00, 1'b0});
        // control keeps 3 bits
        plan.push_back('{REQ_WRITE, 10'd0,    OFF_CTRL,   8'hFF, 1, 8'h00, 1'b0});
        plan.push_back('{REQ_READ,  10'd0,    OFF_CTRL,   8'h00, 1, 8'h07, 1'b0});
        // several overflows in one tick at the fastest rate
        plan.push_back('{REQ_WRITE, 10'd0,    OFF_CTRL,   8'h05, 1, 8'h00, 1'b0});
        plan.push_back('{REQ_WRITE, 10'd0,    OFF_MOD,    8'hFE, 1, 8'h00, 1'b0});
        plan.push_back('{REQ_WRITE, 10'd0,    OFF_CNT,    8'hFF, 1, 8'h00, 1'b0});
        plan.push_back('{REQ_TICK,  10'h3FF,  16'h0000,   8'h00, 1, 8'h00, 1'b1});
        plan.push_back('{REQ_READ,  10'd0,    OFF_CNT,    8'h00, 0, 8'h00, 1'b0});
        plan.push_back('{REQ_POLL,  10'd0,    16'h0000,   8'h00, 1, 8'h00, 1'b1});
        plan.push_back('{REQ_POLL,  10'd0,    16'h0000,   8'h00, 1, 8'h00, 1'b0});
        // unknown offset write is dropped
        plan.push_back('{REQ_WRITE, 10'd0,    16'h8005,   8'h55, 1, 8'h00, 1'b0});
        // period change keeps the leftover fraction
        plan.push_back('{REQ_WRITE, 10'd0,    OFF_CTRL,   8'h04, 1, 8'h00, 1'b0});
        plan.push_back('{REQ_TICK,  10'd1000, 16'h0000,   8'h00, 0, 8'h00, 1'b0});
        plan.push_back('{REQ_WRITE, 10'd0,    OFF_CTRL,   8'h06, 1, 8'h00, 1'b0});
        plan.push_back('{REQ_TICK,  10'd64,   16'h0000,   8'h00, 0, 8'h00, 1'b0});
        plan.push_back('{REQ_READ,  10'd0,    OFF_CNT,    8'h00, 0, 8'h00, 1'b0});

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i])
            issue_request(plan[i]);

        n_random = N_REQUESTS - plan.size();
        for (int i = 0; i < n_random; i++) begin
            // calm windows with no idling, and a calm tail
            no_idle    = ((i % 300) >= 100) && ((i % 300) < 160);
            quiet_tail = (i >= n_random - QUIET_TAIL);
            issue_request(random_request());
        end
        @(negedge aclk);
        s_valid <= 1'b0;

        while (pending_responses.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Hard stop
    initial begin
        #5000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
